// ===== rtl/cfc_pkg.sv =====
// Shared types and constants for the continued-fraction convergent block.
// No dependencies.
`default_nettype none
package cfc_pkg;
   localparam int DataWidth = 64;
   localparam int MagWidth  = DataWidth - 1;
   localparam int TermLimit = 64;
   localparam int CountWidth = 7;

   localparam logic [1:0] CSR_MAX_NUM   = 2'd0;
   localparam logic [1:0] CSR_MAX_DEN   = 2'd1;
   localparam logic [1:0] CSR_MAX_TERMS = 2'd2;

   typedef struct packed {
      logic signed [63:0] numerator;
      logic [62:0]        denominator;
   } req_payload_type;

   typedef struct packed {
      logic signed [63:0] conv_num;
      logic [62:0]        conv_den;
      logic signed [63:0] term;
      logic [62:0]        gcd_value;
      logic               last;
      logic               complete;
   } rsp_payload_type;

   typedef struct packed {
      logic [1:0]  index;
      logic [63:0] data;
   } csr_payload_type;
endpackage
`default_nettype wire

// ===== rtl/cfc_if.sv =====
// Valid/ready channel interface with source and sink modports.
// Depends on nothing; payload type is chosen per instance.
`default_nettype none
interface cfc_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/continued_fraction_convergents.sv =====
// Continued-fraction convergents: one fraction in, one result per term plus a status result.
// Each term runs the bit-serial divider from its start state, then two multiply-adds
// (four 32x32 partial products each, then the signed add), and the result hand-off,
// which waits for the result to be taken. The block takes no request until the status
// result is delivered. Synchronous reset clears control and restores the limit
// registers to their maximum values.
`default_nettype none
module continued_fraction_convergents (
   input wire logic clock,
   input wire logic reset,
   cfc_if.sink   req,
   cfc_if.source rsp,
   cfc_if.sink   csr
);
   import cfc_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001, ST_DIV  = 9'b000000010, ST_WAIT = 9'b000000100,
      ST_MUL0 = 9'b000001000, ST_FIN0 = 9'b000010000, ST_MUL1 = 9'b000100000,
      ST_FIN1 = 9'b001000000, ST_EMIT = 9'b010000000, ST_STAT = 9'b100000000
   } state_type;

   state_type   st_ff, st_in;
   logic [62:0] max_num_ff, max_den_ff;
   logic [6:0]  max_terms_ff;
   logic signed [63:0] wn_ff, wn_in, wd_ff, wd_in;
   logic signed [63:0] p0_ff, p0_in, p1_ff, p1_in, p2_ff, p2_in, p3_ff, p3_in;
   logic signed [63:0] q_ff, q_in, r_ff, r_in, tn_ff, tn_in;
   logic        ovf_ff, ovf_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [1:0]  mstep_ff, mstep_in;
   logic [127:0] acc_ff, acc_in;
   rsp_payload_type out_ff, out_in;
   logic        div_start, div_done;
   logic [63:0] div_q, div_r, num_mag;
   logic [6:0]  limit;

   // Shared multiply-add unit: a*b + c with overflow detection, one partial product a cycle.
   logic signed [63:0] ma_a, ma_b, ma_c, ma_r;
   logic        ma_ovf;
   logic [63:0] ua, ub, uc, m;
   logic [31:0] a_part, b_part;
   logic [63:0] pp;
   logic [127:0] pp_shift;
   logic        sp, sc, neg;
   always_comb begin
      ua = ma_a[63] ? -ma_a : ma_a;
      ub = ma_b[63] ? -ma_b : ma_b;
      uc = ma_c[63] ? -ma_c : ma_c;
      a_part = mstep_ff[0] ? ua[63:32] : ua[31:0];
      b_part = mstep_ff[1] ? ub[63:32] : ub[31:0];
      pp = {32'd0, a_part} * {32'd0, b_part};
      pp_shift = {64'd0, pp} << {mstep_ff[0] & mstep_ff[1], mstep_ff[0] ^ mstep_ff[1], 5'd0};
      sp = (ma_a[63] != ma_b[63]) && (acc_ff != '0);
      sc = ma_c[63];
      ma_ovf = (acc_ff[127:63] != '0) || uc[63];
      neg = sp;
      if (sp == sc) m = acc_ff[63:0] + uc;
      else if (acc_ff[63:0] >= uc) m = acc_ff[63:0] - uc;
      else begin
         m = uc - acc_ff[63:0]; neg = sc;
      end
      if (m[63]) ma_ovf = 1'b1;
      ma_r = neg ? -m : m;
   end

   assign num_mag = wn_ff[63] ? -wn_ff : wn_ff;
   assign limit = (max_terms_ff < 7'(TermLimit)) ? max_terms_ff : 7'(TermLimit);

   cfc_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(num_mag), .divisor(wd_ff),
      .done(div_done), .quotient(div_q), .remainder(div_r)
   );

   assign req.ready = (st_ff == ST_IDLE);
   assign csr.ready = 1'b1;
   assign rsp.valid = (st_ff == ST_EMIT) || (st_ff == ST_STAT);
   assign rsp.payload = out_ff;
   assign div_start = (st_ff == ST_DIV);

   always_comb begin
      ma_a = p0_ff; ma_b = q_ff; ma_c = p2_ff;
      if (st_ff == ST_MUL1 || st_ff == ST_FIN1) begin
         ma_a = p1_ff; ma_c = p3_ff;
      end
   end

   always_comb begin
      st_in = st_ff;
      wn_in = wn_ff; wd_in = wd_ff;
      p0_in = p0_ff; p1_in = p1_ff; p2_in = p2_ff; p3_in = p3_ff;
      q_in = q_ff; r_in = r_ff; tn_in = tn_ff;
      ovf_in = ovf_ff; cnt_in = cnt_ff; out_in = out_ff;
      mstep_in = mstep_ff; acc_in = acc_ff;
      case (st_ff)
         ST_IDLE: if (req.valid) begin
            wn_in = req.payload.numerator;
            wd_in = {1'b0, req.payload.denominator};
            p0_in = 64'sd1; p1_in = '0; p2_in = '0; p3_in = 64'sd1;
            cnt_in = '0;
            st_in = ST_DIV;
         end
         ST_DIV: begin
            if (wd_ff == '0) st_in = ST_STAT;
            else st_in = ST_WAIT;
         end
         ST_WAIT: if (div_done) begin
            // Turn the magnitude quotient into a floor quotient.
            if (!wn_ff[63]) begin
               q_in = div_q; r_in = div_r;
            end else if (div_r == '0) begin
               q_in = -div_q; r_in = '0;
            end else begin
               q_in = -div_q - 64'sd1; r_in = wd_ff - div_r;
            end
            mstep_in = '0; acc_in = '0;
            st_in = ST_MUL0;
         end
         ST_MUL0: begin
            acc_in = acc_ff + pp_shift;
            mstep_in = mstep_ff + 2'd1;
            if (mstep_ff == 2'd3) st_in = ST_FIN0;
         end
         ST_FIN0: begin
            tn_in = ma_r; ovf_in = ma_ovf;
            mstep_in = '0; acc_in = '0;
            st_in = ST_MUL1;
         end
         ST_MUL1: begin
            acc_in = acc_ff + pp_shift;
            mstep_in = mstep_ff + 2'd1;
            if (mstep_ff == 2'd3) st_in = ST_FIN1;
         end
         ST_FIN1: begin
            if (ovf_ff || ma_ovf ||
                (!tn_ff[63] && tn_ff[62:0] > max_num_ff) ||
                (!ma_r[63] && ma_r[62:0] > max_den_ff) ||
                (cnt_ff + 7'd1 >= limit)) begin
               st_in = ST_STAT;
            end else begin
               cnt_in = cnt_ff + 7'd1;
               out_in.conv_num = tn_ff;
               out_in.conv_den = ma_r[62:0];
               out_in.term = q_ff;
               out_in.gcd_value = (r_ff == '0) ? wd_ff[62:0] : '0;
               out_in.last = 1'b0; out_in.complete = 1'b0;
               p2_in = p0_ff; p3_in = p1_ff; p0_in = tn_ff; p1_in = ma_r;
               wn_in = wd_ff; wd_in = r_ff;
               st_in = ST_EMIT;
            end
            if (st_in == ST_STAT) begin
               out_in = '0; out_in.last = 1'b1; out_in.complete = 1'b0;
            end
         end
         ST_EMIT: if (rsp.ready) st_in = ST_DIV;
         ST_STAT: if (rsp.ready) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
      if (st_ff == ST_DIV && wd_ff == '0) begin
         out_in = '0; out_in.last = 1'b1; out_in.complete = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      wn_ff <= wn_in; wd_ff <= wd_in;
      p0_ff <= p0_in; p1_ff <= p1_in; p2_ff <= p2_in; p3_ff <= p3_in;
      q_ff <= q_in; r_ff <= r_in; tn_ff <= tn_in;
      ovf_ff <= ovf_in; cnt_ff <= cnt_in; out_ff <= out_in;
      mstep_ff <= mstep_in; acc_ff <= acc_in;
      if (reset) begin
         st_ff <= ST_IDLE;
         max_num_ff <= '1; max_den_ff <= '1; max_terms_ff <= 7'(TermLimit);
      end else begin
         st_ff <= st_in;
         if (csr.valid) begin
            case (csr.payload.index)
               CSR_MAX_NUM:   max_num_ff <= csr.payload.data[62:0];
               CSR_MAX_DEN:   max_den_ff <= csr.payload.data[62:0];
               CSR_MAX_TERMS: max_terms_ff <= csr.payload.data[6:0];
               default: ;
            endcase
         end
      end
   end
endmodule
`default_nettype wire

// ===== rtl/cfc_divider.sv =====
// Restoring bit-serial divider for 64-bit magnitudes, one quotient bit per cycle.
// Depends on cfc_pkg.
`default_nettype none
module cfc_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] dividend,
   input  wire logic [63:0] divisor,
   output logic             done,
   output logic [63:0]      quotient,
   output logic [63:0]      remainder
);
   import cfc_pkg::*;
   logic [63:0] quo_ff, quo_in, rem_ff, rem_in;
   logic [63:0] dvs_ff, dvs_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [64:0] trial;

   always_comb begin
      quo_in = quo_ff; rem_in = rem_ff; dvs_in = dvs_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff, quo_ff[63]} - {1'b0, dvs_ff};
      if (start) begin
         quo_in = dividend; rem_in = '0; dvs_in = divisor;
         cnt_in = 7'd64; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[64]) begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[62:0], quo_ff[63]};
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in; rem_ff <= rem_in; dvs_ff <= dvs_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire
